/* rtl/core/lrse_pkg.sv */
package lrse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int DEPTH_BITS  = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] ID_MASK = 8'((1 << ID_BITS) - 1);

    typedef logic [DEPTH_BITS-1:0] t_depth;

    typedef enum logic [3:0] {
        CMD_START     = 4'd0,
        CMD_READ      = 4'd1,
        CMD_NOT_TOP   = 4'd2,
        CMD_AND       = 4'd3,
        CMD_AND_NOT   = 4'd4,
        CMD_OR        = 4'd5,
        CMD_OR_NOT    = 4'd6,
        CMD_WRITE     = 4'd7,
        CMD_WRITE_NOT = 4'd8,
        CMD_TIMER     = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_COMBINE,
        STK_NEGATE
    } t_stack_op;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_UP,
        CELL_TAKE_DOWN,
        CELL_INVERT
    } t_cell_op;

    typedef struct packed {
        t_stack_op op;
        logic      push_bit;
        logic      comb_bit;
    } t_stack_ctrl;

endpackage

/* rtl/core/lrse_if.sv */
interface lrse_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [7:0]  operand_id;
    logic        contact_value;
    logic        contact_present;
    logic [15:0] interval_ms;
    logic        interval_valid;

    modport source (
        output valid, command, operand_id, contact_value, contact_present,
               interval_ms, interval_valid,
        input  ready
    );
    modport sink (
        input  valid, command, operand_id, contact_value, contact_present,
               interval_ms, interval_valid,
        output ready
    );
endinterface

interface lrse_coil_if;
    logic        valid;
    logic        ready;
    logic [7:0]  coil_id;
    logic        coil_value;
    logic [15:0] wait_ms;

    modport source (
        output valid, coil_id, coil_value, wait_ms,
        input  ready
    );
    modport sink (
        input  valid, coil_id, coil_value, wait_ms,
        output ready
    );
endinterface

/* rtl/core/lrse_cell.sv */
module lrse_cell (
    input  logic              i_clk,
    input  lrse_pkg::t_cell_op i_op,
    input  logic              i_up,
    input  logic              i_down,
    output logic              o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        case (i_op)
            lrse_pkg::CELL_HOLD:      n_bit = r_bit;
            lrse_pkg::CELL_TAKE_UP:   n_bit = i_up;
            lrse_pkg::CELL_TAKE_DOWN: n_bit = i_down;
            lrse_pkg::CELL_INVERT:    n_bit = ~r_bit;
            default:                  n_bit = r_bit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

/* rtl/core/lrse_stack.sv */
module lrse_stack (
    input  logic                 i_clk,
    input  lrse_pkg::t_stack_ctrl i_ctrl,
    output logic                 o_top,
    output logic                 o_below
);

    logic [lrse_pkg::STACK_DEPTH-1:0] w_bit;

    genvar g;
    generate
        for (g = 0; g < lrse_pkg::STACK_DEPTH; g++) begin : g_cell
            lrse_pkg::t_cell_op w_op;
            logic               w_up;
            logic               w_down;

            if (g == 0) begin : g_head
                always_comb begin
                    case (i_ctrl.op)
                        lrse_pkg::STK_PUSH:    w_op = lrse_pkg::CELL_TAKE_UP;
                        lrse_pkg::STK_COMBINE: w_op = lrse_pkg::CELL_TAKE_UP;
                        lrse_pkg::STK_NEGATE:  w_op = lrse_pkg::CELL_INVERT;
                        default:               w_op = lrse_pkg::CELL_HOLD;
                    endcase
                end
                assign w_up = (i_ctrl.op == lrse_pkg::STK_PUSH) ? i_ctrl.push_bit
                                                                : i_ctrl.comb_bit;
            end else begin : g_body
                always_comb begin
                    case (i_ctrl.op)
                        lrse_pkg::STK_PUSH:    w_op = lrse_pkg::CELL_TAKE_UP;
                        lrse_pkg::STK_COMBINE: w_op = lrse_pkg::CELL_TAKE_DOWN;
                        default:               w_op = lrse_pkg::CELL_HOLD;
                    endcase
                end
                assign w_up = w_bit[g-1];
            end

            if (g == lrse_pkg::STACK_DEPTH - 1) begin : g_tail
                assign w_down = 1'b0;
            end else begin : g_link
                assign w_down = w_bit[g+1];
            end

            lrse_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_op),
                .i_up   (w_up),
                .i_down (w_down),
                .o_bit  (w_bit[g])
            );
        end
    endgenerate

    assign o_top   = w_bit[0];
    assign o_below = w_bit[1];

endmodule

/* rtl/core/ladder_rung_stack_evaluator_top.sv */
// Ladder rung evaluator.
// Tokens of a rung enter on i_tok (valid/ready). Each token is one word:
// command, operand id, contact value and presence, timer interval and its
// valid flag. Coil writes leave on o_coil as one word each: coil id, value
// and the pending wait in ms.
// The bit stack is a row of one-bit cells with the top in the first cell;
// a push or a pop-and-combine moves every cell together and a negate
// inverts the top cell; one token is taken per cycle unless o_coil stalls.
// A write token shows its word on o_coil in the cycle after it is accepted.
// The output register refills in the same cycle it drains, so a token is
// taken whenever o_coil is empty or being read; while the receiver holds
// o_coil.ready low with a word waiting, i_tok.ready stays low.
// A fault aborts the rung: later tokens are taken and dropped until a
// start token.
// Reset clears the depth, abort flag, pending wait and output valid; the
// stack cells are not cleared, and only filled cells are ever read.
module ladder_rung_stack_evaluator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrse_tok_if.sink   i_tok,
    lrse_coil_if.source o_coil
);

    lrse_pkg::t_depth     r_depth;
    lrse_pkg::t_depth     n_depth;
    logic                 r_aborted;
    logic                 n_aborted;
    logic [15:0]          r_wait;
    logic [15:0]          n_wait;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [7:0]           r_coil_id;
    logic                 r_coil_value;
    logic [15:0]          r_wait_ms;

    logic                 w_accept;
    logic                 w_emit;
    logic                 w_top;
    logic                 w_below;
    logic                 w_top_eff;
    lrse_pkg::t_cmd       w_cmd;
    lrse_pkg::t_stack_ctrl w_ctrl;

    assign w_cmd    = lrse_pkg::t_cmd'(i_tok.command);
    assign i_tok.ready = ~r_out_valid | o_coil.ready;
    assign w_accept = i_tok.valid & i_tok.ready;

    lrse_stack u_stack (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .o_top   (w_top),
        .o_below (w_below)
    );

    assign w_top_eff = (w_cmd == lrse_pkg::CMD_AND_NOT || w_cmd == lrse_pkg::CMD_OR_NOT)
                     ? ~w_top : w_top;

    always_comb begin
        n_depth        = r_depth;
        n_aborted      = r_aborted;
        n_wait         = r_wait;
        w_emit         = 1'b0;
        w_ctrl.op      = lrse_pkg::STK_HOLD;
        w_ctrl.push_bit = i_tok.contact_value;
        w_ctrl.comb_bit = (w_cmd == lrse_pkg::CMD_AND || w_cmd == lrse_pkg::CMD_AND_NOT)
                        ? (w_top_eff & w_below) : (w_top_eff | w_below);
        if (w_accept) begin
            if (w_cmd == lrse_pkg::CMD_START) begin
                n_depth   = '0;
                n_aborted = 1'b0;
                n_wait    = '0;
            end else if (!r_aborted) begin
                case (w_cmd)
                    lrse_pkg::CMD_READ: begin
                        if (!i_tok.contact_present ||
                            r_depth == lrse_pkg::t_depth'(lrse_pkg::STACK_DEPTH)) begin
                            n_aborted = 1'b1;
                        end else begin
                            w_ctrl.op = lrse_pkg::STK_PUSH;
                            n_depth   = r_depth + lrse_pkg::t_depth'(1);
                        end
                    end
                    lrse_pkg::CMD_NOT_TOP: begin
                        if (r_depth == '0) begin
                            n_aborted = 1'b1;
                        end else begin
                            w_ctrl.op = lrse_pkg::STK_NEGATE;
                        end
                    end
                    lrse_pkg::CMD_AND, lrse_pkg::CMD_AND_NOT,
                    lrse_pkg::CMD_OR, lrse_pkg::CMD_OR_NOT: begin
                        if (r_depth < lrse_pkg::t_depth'(2)) begin
                            n_aborted = 1'b1;
                        end else begin
                            w_ctrl.op = lrse_pkg::STK_COMBINE;
                            n_depth   = r_depth - lrse_pkg::t_depth'(1);
                        end
                    end
                    lrse_pkg::CMD_WRITE, lrse_pkg::CMD_WRITE_NOT: begin
                        if (r_depth != lrse_pkg::t_depth'(1)) begin
                            n_aborted = 1'b1;
                        end else begin
                            w_emit = 1'b1;
                        end
                    end
                    lrse_pkg::CMD_TIMER: begin
                        if (i_tok.interval_valid) begin
                            n_wait = i_tok.interval_ms;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_coil.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_aborted   <= 1'b0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth     <= n_depth;
            r_aborted   <= n_aborted;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_coil_id    <= i_tok.operand_id & lrse_pkg::ID_MASK;
            r_coil_value <= (w_cmd == lrse_pkg::CMD_WRITE_NOT) ? ~w_top : w_top;
            r_wait_ms    <= r_wait;
        end
    end

    assign o_coil.valid      = r_out_valid;
    assign o_coil.coil_id    = r_coil_id;
    assign o_coil.coil_value = r_coil_value;
    assign o_coil.wait_ms    = r_wait_ms;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= lrse_pkg::t_depth'(lrse_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_abort_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_aborted && w_cmd != lrse_pkg::CMD_START)
        |=> ($stable(r_depth) && $stable(r_wait) && r_aborted))
        else $error("aborted rung changed state");

    a_bad_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == lrse_pkg::CMD_WRITE || w_cmd == lrse_pkg::CMD_WRITE_NOT)
         && r_depth != lrse_pkg::t_depth'(1)) |=> r_aborted)
        else $error("write at bad depth did not abort");

    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == lrse_pkg::CMD_START)
        |=> (r_depth == '0 && !r_aborted && r_wait == '0))
        else $error("start did not clear rung state");

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]  command;
        logic [7:0]  operand_id;
        logic        contact_value;
        logic        contact_present;
        logic [15:0] interval_ms;
        logic        interval_valid;
    } t_tok_word;

    typedef struct {
        logic [7:0]  coil_id;
        logic        coil_value;
        logic [15:0] wait_ms;
    } t_coil_word;

    logic i_clk;
    logic i_rst_n;

    lrse_tok_if  tok ();
    lrse_coil_if coil ();

    ladder_rung_stack_evaluator_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok),
        .o_coil  (coil)
    );

    // rung state of the predictor
    logic [lrse_pkg::STACK_DEPTH-1:0] stk_m;
    lrse_pkg::t_depth                 depth_m;
    logic                             abort_m;
    logic [15:0]                      wait_m;

    t_coil_word pending_coils[$];

    int  err_count   = 0;
    int  tok_count   = 0;
    int  coil_count  = 0;
    int  fault_count = 0;
    bit  tx_idle_en  = 1'b1;
    bit  rx_idle_en  = 1'b1;
    int  rx_hold     = 0;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic eval_token(input t_tok_word w);
        logic       top;
        logic       below;
        logic       res;
        t_coil_word cw;
        if (w.command == lrse_pkg::CMD_START) begin
            depth_m = '0;
            abort_m = 1'b0;
            wait_m  = '0;
        end else if (!abort_m) begin
            case (w.command)
                lrse_pkg::CMD_READ: begin
                    if (!w.contact_present || depth_m >= lrse_pkg::STACK_DEPTH) begin
                        abort_m = 1'b1;
                    end else begin
                        stk_m[depth_m] = w.contact_value;
                        depth_m++;
                    end
                end
                lrse_pkg::CMD_NOT_TOP: begin
                    if (depth_m == 0) begin
                        abort_m = 1'b1;
                    end else begin
                        stk_m[depth_m-1] = ~stk_m[depth_m-1];
                    end
                end
                lrse_pkg::CMD_AND, lrse_pkg::CMD_AND_NOT,
                lrse_pkg::CMD_OR, lrse_pkg::CMD_OR_NOT: begin
                    if (depth_m < 2) begin
                        abort_m = 1'b1;
                    end else begin
                        top   = stk_m[depth_m-1];
                        below = stk_m[depth_m-2];
                        if (w.command == lrse_pkg::CMD_AND_NOT ||
                            w.command == lrse_pkg::CMD_OR_NOT)
                            top = ~top;
                        if (w.command == lrse_pkg::CMD_AND ||
                            w.command == lrse_pkg::CMD_AND_NOT)
                            res = top & below;
                        else
                            res = top | below;
                        depth_m--;
                        stk_m[depth_m-1] = res;
                    end
                end
                lrse_pkg::CMD_WRITE, lrse_pkg::CMD_WRITE_NOT: begin
                    if (depth_m != 1) begin
                        abort_m = 1'b1;
                    end else begin
                        cw.coil_id    = w.operand_id & lrse_pkg::ID_MASK;
                        cw.coil_value = stk_m[0] ^ (w.command == lrse_pkg::CMD_WRITE_NOT);
                        cw.wait_ms    = wait_m;
                        pending_coils.push_back(cw);
                    end
                end
                lrse_pkg::CMD_TIMER: begin
                    if (w.interval_valid)
                        wait_m = w.interval_ms;
                end
                default: ;
            endcase
            if (abort_m)
                fault_count++;
        end
    endtask

    function automatic t_tok_word mk(input logic [3:0] cmd, input logic [7:0] id,
                                     input logic cv, input logic cp,
                                     input logic [15:0] iv, input logic ivv);
        t_tok_word w;
        w.command         = cmd;
        w.operand_id      = id;
        w.contact_value   = cv;
        w.contact_present = cp;
        w.interval_ms     = iv;
        w.interval_valid  = ivv;
        return w;
    endfunction

    function automatic t_tok_word rand_word(input logic [3:0] cmd);
        t_tok_word w;
        w.command         = cmd;
        w.operand_id      = 8'($urandom);
        w.contact_value   = 1'($urandom);
        w.contact_present = ($urandom_range(99) < 97);
        w.interval_ms     = 16'($urandom);
        w.interval_valid  = ($urandom_range(9) != 0);
        return w;
    endfunction

    task automatic send_word(input t_tok_word w);
        if (tx_idle_en && $urandom_range(99) < 5) begin
            tok.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        tok.valid           <= 1'b1;
        tok.command         <= w.command;
        tok.operand_id      <= w.operand_id;
        tok.contact_value   <= w.contact_value;
        tok.contact_present <= w.contact_present;
        tok.interval_ms     <= w.interval_ms;
        tok.interval_valid  <= w.interval_valid;
        do @(posedge i_clk); while (tok.ready !== 1'b1);
        eval_token(w);
        tok_count++;
    endtask

    task automatic wait_drain();
        tok.valid <= 1'b0;
        while (pending_coils.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_combine();
        logic [3:0] op;
        op = 4'(lrse_pkg::CMD_AND) + 4'($urandom_range(3));
        send_word(rand_word(op));
    endtask

    // one rung: mostly well formed, some faults and noise mixed in
    task automatic send_rung();
        int  leaves;
        int  d;
        int  n_wr;
        int  r;
        bit  deep;
        bit  short_write;
        if ($urandom_range(19) != 0)
            send_word(rand_word(lrse_pkg::CMD_START));
        if ($urandom_range(2) == 0)
            send_word(rand_word(lrse_pkg::CMD_TIMER));
        r = $urandom_range(99);
        if (r < 4)
            leaves = lrse_pkg::STACK_DEPTH + 1;
        else if (r < 10)
            leaves = lrse_pkg::STACK_DEPTH;
        else
            leaves = $urandom_range(1, 5);
        deep = (leaves >= lrse_pkg::STACK_DEPTH);
        d = 0;
        for (int i = 0; i < leaves; i++) begin
            send_word(rand_word(lrse_pkg::CMD_READ));
            d++;
            if (!deep && $urandom_range(99) < 15)
                send_word(rand_word(lrse_pkg::CMD_NOT_TOP));
            if (!deep && d >= 2 && $urandom_range(1) == 0) begin
                send_combine();
                d--;
            end
        end
        short_write = ($urandom_range(19) == 0);
        while (d > (short_write ? 2 : 1)) begin
            if ($urandom_range(99) < 10)
                send_word(rand_word(lrse_pkg::CMD_NOT_TOP));
            send_combine();
            d--;
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 2))
                send_word(rand_word(4'($urandom_range(15))));
        end
        n_wr = $urandom_range(1, 3);
        for (int i = 0; i < n_wr; i++) begin
            if ($urandom_range(9) < 3)
                send_word(rand_word(lrse_pkg::CMD_TIMER));
            send_word(rand_word($urandom_range(1) ? lrse_pkg::CMD_WRITE
                                                  : lrse_pkg::CMD_WRITE_NOT));
        end
    endtask

    task automatic run_rungs(input int n_items);
        int first;
        first = tok_count;
        while (tok_count - first < n_items)
            send_rung();
    endtask

    task automatic test_directed();
        send_word(mk(lrse_pkg::CMD_READ,      8'hFF, 1'b1, 1'b1, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_WRITE,     8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_START,     8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_TIMER,     8'h01, 1'b0, 1'b0, 16'hFFFF, 1'b1));
        send_word(mk(lrse_pkg::CMD_TIMER,     8'h02, 1'b1, 1'b1, 16'h1234, 1'b0));
        send_word(mk(lrse_pkg::CMD_READ,      8'h10, 1'b1, 1'b1, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_READ,      8'h11, 1'b0, 1'b1, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_AND,       8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_READ,      8'h12, 1'b1, 1'b1, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_OR_NOT,    8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_READ,      8'h13, 1'b0, 1'b1, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_AND_NOT,   8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_READ,      8'h14, 1'b1, 1'b1, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_OR,        8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_NOT_TOP,   8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_WRITE_NOT, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_WRITE,     8'hA5, 1'b1, 1'b1, 16'hFFFF, 1'b1));
        send_word(mk(4'd15,                   8'hFF, 1'b1, 1'b1, 16'hFFFF, 1'b1));
        send_word(mk(4'd10,                   8'h5A, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_READ,      8'h20, 1'b1, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_WRITE,     8'h21, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_START,     8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_NOT_TOP,   8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_START,     8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        send_word(mk(lrse_pkg::CMD_AND,       8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
        wait_drain();
    endtask

    // hold the coil side off so the output fills and the token side stalls
    task automatic test_backpressure();
        rx_hold = 120;
        run_rungs(80);
        wait_drain();
    endtask

    task automatic test_streaming();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_rungs(200);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_random_rungs();
        for (int i = 0; i < 5; i++) begin
            run_rungs(110);
            if ($urandom_range(1) == 0)
                wait_drain();
        end
    endtask

    // coil side: random idling, long hold-off on request
    initial begin
        coil.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                coil.ready <= 1'b0;
                rx_hold--;
            end else if (rx_idle_en) begin
                coil.ready <= ($urandom_range(99) >= 9);
            end else begin
                coil.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_coil_word cw;
        if (i_rst_n && coil.valid === 1'b1 && coil.ready === 1'b1) begin
            coil_count++;
            if (pending_coils.size() == 0) begin
                report_mismatch($sformatf("unexpected coil word id=%0h val=%0b wait=%0h",
                                          coil.coil_id, coil.coil_value, coil.wait_ms));
            end else begin
                cw = pending_coils.pop_front();
                if (coil.coil_id !== cw.coil_id)
                    report_mismatch($sformatf("coil_id got %0h exp %0h",
                                              coil.coil_id, cw.coil_id));
                if (coil.coil_value !== cw.coil_value)
                    report_mismatch($sformatf("coil_value got %0b exp %0b",
                                              coil.coil_value, cw.coil_value));
                if (coil.wait_ms !== cw.wait_ms)
                    report_mismatch($sformatf("wait_ms got %0h exp %0h",
                                              coil.wait_ms, cw.wait_ms));
            end
        end
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int guard;
        i_rst_n             = 1'b0;
        tok.valid           = 1'b0;
        tok.command         = '0;
        tok.operand_id      = '0;
        tok.contact_value   = 1'b0;
        tok.contact_present = 1'b0;
        tok.interval_ms     = '0;
        tok.interval_valid  = 1'b0;
        stk_m               = '0;
        depth_m             = '0;
        abort_m             = 1'b0;
        wait_m              = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_streaming();
        test_random_rungs();

        tok.valid <= 1'b0;
        guard = 0;
        while (pending_coils.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_coils.size() != 0)
            report_mismatch($sformatf("%0d coil words never arrived", pending_coils.size()));

        $display("Sent %0d tokens in rungs up to full stack depth, %0d faults hit,",
                 tok_count, fault_count);
        $display("checked %0d coil words under idling, stalls and a long output hold-off.",
                 coil_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
